>>> rtl/running_average_ring_top_defines.svh
// ----------------------------------------------------------------------------
// Running average ring: assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef RUNNING_AVERAGE_RING_TOP_DEFINES_SVH
`define RUNNING_AVERAGE_RING_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define RAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define RAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RAR_ASSERT(lbl, prop, msg)
`define RAR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/rar_pkg.sv
// ----------------------------------------------------------------------------
// Running average ring: package
// Shared widths, reset constants, control state and divider status types.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WIN_W    = 6;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/rar_sample_if.sv
// ----------------------------------------------------------------------------
// Running average ring: sample channel
// Valid/ready channel carrying one signed sample per transaction.
// ----------------------------------------------------------------------------
interface rar_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [rar_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> rtl/rar_average_if.sv
// ----------------------------------------------------------------------------
// Running average ring: average channel
// Valid/ready channel carrying one signed average per transaction.
// ----------------------------------------------------------------------------
interface rar_average_if;
  logic                                valid;
  logic                                ready;
  logic signed [rar_pkg::SAMPLE_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

>>> rtl/rar_div.sv
// ----------------------------------------------------------------------------
// Running average ring: sum divider
// Bit-serial restoring divider, signed dividend by positive count, one
// quotient bit per cycle, result truncated toward zero.
// ----------------------------------------------------------------------------
module rar_div #(
  parameter int SUM_W = 37,
  parameter int CNT_W = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [SUM_W-1:0]             dividend_i,
  input  logic        [CNT_W-1:0]             divisor_i,
  output rar_pkg::div_status_t                status_o,
  output logic signed [rar_pkg::SAMPLE_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  mag_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;
  logic              neg_q;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              fits;
  logic [rar_pkg::SAMPLE_W-1:0] q_mag;

  always_comb begin
    rem_sh  = {rem_q, mag_q[SUM_W-1]};
    fits    = rem_sh >= {1'b0, div_q};
    rem_sub = rem_sh - {1'b0, div_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SUM_W - 1);
    end else if (busy_q) begin
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      mag_q <= dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      mag_q <= {mag_q[SUM_W-2:0], fits};
      rem_q <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  assign q_mag           = mag_q[rar_pkg::SAMPLE_W-1:0];
  assign quotient_o      = neg_q ? $signed(-q_mag) : $signed(q_mag);
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

>>> rtl/running_average_ring_top.sv
// ----------------------------------------------------------------------------
// Running average ring: top level
// Simple moving average over the last window_size samples.
// ----------------------------------------------------------------------------
// One sample in, one average out per transaction. The block takes a sample,
// reads the oldest ring entry from the sample memory, updates the running
// sum and writes the new sample back, then divides the sum by the fill count
// in a bit-serial divider and loads the output register once it is free. A
// new sample is taken while the previous average still waits in the output
// register. Ring entries not yet written since the last clear read as zero
// through the fill count, so no clearing pass is needed. Writing the window
// register clears the filter; write it only while the block is idle. Window
// values of zero act as one, values above WINDOW_MAX as WINDOW_MAX.
// ----------------------------------------------------------------------------
`include "running_average_ring_top_defines.svh"

module running_average_ring_top #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rar_sample_if.sink                   sample_i,
  rar_average_if.source                average_o,
  input  logic                         cfg_we_i,
  input  logic [rar_pkg::WIN_W-1:0]    cfg_wdata_i
);

  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = rar_pkg::SAMPLE_W + $clog2(WINDOW_MAX);

  rar_pkg::state_e state_q, state_d;

  logic [rar_pkg::WIN_W-1:0]           win_q;
  logic [CNT_W-1:0]                    win_eff;
  logic [AW-1:0]                       pos_q, pos_d;
  logic [CNT_W-1:0]                    cnt_q, cnt_d;
  logic signed [SUM_W-1:0]             sum_q, sum_d;
  logic signed [SUM_W:0]               sum_ext;
  logic signed [rar_pkg::SAMPLE_W-1:0] sample_q;
  logic signed [rar_pkg::SAMPLE_W-1:0] old_val;
  logic [CNT_W-1:0]                    pos_inc;

  logic [rar_pkg::SAMPLE_W-1:0]        ring_mem [WINDOW_MAX];
  logic [rar_pkg::SAMPLE_W-1:0]        rd_data_q;

  logic                                out_valid_q;
  logic signed [rar_pkg::SAMPLE_W-1:0] average_q;

  logic                                in_fire;
  logic                                upd;
  logic                                out_load;
  logic                                div_start;
  rar_pkg::div_status_t                div_stat;
  logic signed [rar_pkg::SAMPLE_W-1:0] div_quot;

  always_comb begin
    if (win_q == '0) begin
      win_eff = CNT_W'(1);
    end else if (int'(win_q) > WINDOW_MAX) begin
      win_eff = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff = CNT_W'(win_q);
    end
  end

  assign sample_i.ready = (state_q == rar_pkg::ST_IDLE);
  assign in_fire        = sample_i.valid && sample_i.ready;

  // read-modify-write of the ring slot
  always_comb begin
    old_val = (cnt_q >= win_eff) ? $signed(rd_data_q) : '0;
    sum_ext = (SUM_W+1)'(sum_q) - (SUM_W+1)'(old_val) + (SUM_W+1)'(sample_q);
    sum_d   = sum_ext[SUM_W-1:0];
    pos_inc = CNT_W'(pos_q) + 1'b1;
    pos_d   = (pos_inc >= win_eff) ? '0 : pos_inc[AW-1:0];
    cnt_d   = (cnt_q < win_eff) ? cnt_q + 1'b1 : win_eff;
  end

  always_comb begin
    state_d   = state_q;
    upd       = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      rar_pkg::ST_IDLE: begin
        if (in_fire) state_d = rar_pkg::ST_READ;
      end
      rar_pkg::ST_READ: begin
        upd       = 1'b1;
        div_start = 1'b1;
        state_d   = rar_pkg::ST_DIV;
      end
      rar_pkg::ST_DIV: begin
        if (div_stat.done) state_d = rar_pkg::ST_OUT;
      end
      rar_pkg::ST_OUT: begin
        if (!out_valid_q || average_o.ready) begin
          out_load = 1'b1;
          state_d  = rar_pkg::ST_IDLE;
        end
      end
      default: state_d = rar_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rar_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= rar_pkg::WINDOW_RESET;
      pos_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
      pos_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
    end else if (upd) begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_data_q <= ring_mem[pos_q];
    end
    if (upd) begin
      ring_mem[pos_q] <= sample_q;
    end
  end

  rar_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (cnt_d),
    .status_o   (div_stat),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (average_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      average_q <= div_quot;
    end
  end

  assign average_o.valid   = out_valid_q;
  assign average_o.average = average_q;

  `RAR_ASSERT_ALWAYS(a_cnt_le_win, cnt_q <= win_eff, "fill count exceeds window")
  `RAR_ASSERT_ALWAYS(a_pos_lt_win, CNT_W'(pos_q) < win_eff, "write position out of window")
  `RAR_ASSERT(a_done_in_div, div_stat.done |-> state_q == rar_pkg::ST_DIV,
              "divider finished outside the divide state")
  `RAR_ASSERT(a_ready_not_busy, sample_i.ready |-> !div_stat.busy,
              "sample taken while divider busy")

endmodule
